[src/ufmf_pkg.sv]
package ufmf_pkg;

   localparam int READINGS   = 13;
   localparam int MID_INDEX  = READINGS / 2;
   localparam int COUNT_W    = $clog2(READINGS + 1);

   localparam int ACTION_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int TICK_W     = 10;
   localparam int GAP_W      = 8;
   localparam int PROD_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

   localparam logic KIND_TRIGGER = 1'b0;
   localparam logic KIND_MEDIAN  = 1'b1;

   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_GAP     = 1'b1;

   localparam logic [BYTE_W-1:0]  HEADER_BYTE    = 8'hFF;
   localparam logic [VALUE_W-1:0] VALUE_TIMEOUT  = 16'hFFFF;
   localparam logic [VALUE_W-1:0] VALUE_CSUM_ERR = 16'hFFFE;
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET  = 10'd200;
   localparam logic [GAP_W-1:0]   GAP_RESET      = 8'd15;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [VALUE_W-1:0] RECIP_TEN   = 16'd52429;
   localparam int                 RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      RD_QUOT,
      RD_CSUM_ERR,
      RD_TIMEOUT
   } reading_sel_type;

   typedef struct packed {
      logic                latch_byte;
      logic                store_hi;
      logic                store_lo;
      logic                clr_elapsed;
      logic                inc_elapsed;
      logic                load_reading;
      reading_sel_type     reading_sel;
      logic                insert;
      logic [COUNT_W-1:0]  insert_count;
      logic                load_out;
      logic                out_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic byte_is_header;
      logic csum_ok;
      logic timeout_hit;
      logic gap_done;
      logic gap_zero;
   } dp_status_type;

endpackage

[src/ufmf_req_if.sv]
interface ufmf_req_if;
   import ufmf_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

[src/ufmf_rsp_if.sv]
interface ufmf_rsp_if;
   import ufmf_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

[src/ufmf_csr.sv]
module ufmf_csr
   import ufmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TICK_W-1:0]     timeout_ms,
   output logic [GAP_W-1:0]      gap_ms
);

   logic [TICK_W-1:0] timeout_ff;
   logic [GAP_W-1:0]  gap_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         gap_ff     <= GAP_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_TIMEOUT: timeout_ff <= csr_pwdata[TICK_W-1:0];
            REG_GAP:     gap_ff     <= csr_pwdata[GAP_W-1:0];
            default:     timeout_ff <= timeout_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TIMEOUT: csr_prdata = CSR_DATA_W'(timeout_ff);
         REG_GAP:     csr_prdata = CSR_DATA_W'(gap_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign timeout_ms = timeout_ff;
   assign gap_ms     = gap_ff;

endmodule

[src/ufmf_dpath.sv]
module ufmf_dpath
   import ufmf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [BYTE_W-1:0]   rx_byte,
   input  logic [TICK_W-1:0]   timeout_ms,
   input  logic [GAP_W-1:0]    gap_ms,
   output logic                rsp_kind,
   output logic [VALUE_W-1:0]  rsp_value
);

   logic [BYTE_W-1:0]  byte_ff;
   logic [BYTE_W-1:0]  frame_hi_ff;
   logic [BYTE_W-1:0]  frame_lo_ff;
   logic [BYTE_W-1:0]  sum8;
   logic [PROD_W-1:0]  product_ff;
   logic [VALUE_W-1:0] quot;
   logic [TICK_W-1:0]  elapsed_ff;
   logic [TICK_W-1:0]  elapsed_inc;
   logic [VALUE_W-1:0] reading_ff;
   logic [VALUE_W-1:0] sorted_ff   [READINGS];
   logic [VALUE_W-1:0] sorted_in   [READINGS];
   logic [VALUE_W-1:0] prev_val    [READINGS];
   logic               gt          [READINGS];
   logic               prev_gt     [READINGS];
   logic               kind_ff;
   logic [VALUE_W-1:0] value_ff;

   assign sum8        = HEADER_BYTE + frame_hi_ff + frame_lo_ff;
   assign quot        = VALUE_W'(product_ff[PROD_W-1:RECIP_SHIFT]);
   assign elapsed_inc = elapsed_ff + 1'b1;

   assign status.byte_is_header = (byte_ff == HEADER_BYTE);
   assign status.csum_ok        = (sum8 == byte_ff);
   assign status.timeout_hit    = (elapsed_ff >= timeout_ms);
   assign status.gap_done       = (elapsed_inc >= TICK_W'(gap_ms));
   assign status.gap_zero       = (gap_ms == '0);

   // parallel insertion: every slot decides on its own from its neighbor
   always_comb begin
      for (int i = 0; i < READINGS; i++) begin
         gt[i] = sorted_ff[i] > reading_ff;
      end
      prev_gt[0]  = 1'b0;
      prev_val[0] = reading_ff;
      for (int i = 1; i < READINGS; i++) begin
         prev_gt[i]  = gt[i-1];
         prev_val[i] = sorted_ff[i-1];
      end
      sorted_in = sorted_ff;
      if (cmd.insert) begin
         for (int i = 0; i < READINGS; i++) begin
            if ((COUNT_W'(i) == cmd.insert_count) ||
                ((COUNT_W'(i) < cmd.insert_count) && gt[i])) begin
               sorted_in[i] = prev_gt[i] ? prev_val[i] : reading_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else if (cmd.clr_elapsed) begin
         elapsed_ff <= '0;
      end else if (cmd.inc_elapsed) begin
         elapsed_ff <= elapsed_inc;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= PROD_W'({frame_hi_ff, frame_lo_ff}) * PROD_W'(RECIP_TEN);
      sorted_ff  <= sorted_in;
      if (cmd.latch_byte) begin
         byte_ff <= rx_byte;
      end
      if (cmd.store_hi) begin
         frame_hi_ff <= byte_ff;
      end
      if (cmd.store_lo) begin
         frame_lo_ff <= byte_ff;
      end
      if (cmd.load_reading) begin
         case (cmd.reading_sel)
            RD_QUOT:     reading_ff <= quot;
            RD_CSUM_ERR: reading_ff <= VALUE_CSUM_ERR;
            RD_TIMEOUT:  reading_ff <= VALUE_TIMEOUT;
            default:     reading_ff <= VALUE_TIMEOUT;
         endcase
      end
      if (cmd.load_out) begin
         kind_ff  <= cmd.out_kind;
         value_ff <= (cmd.out_kind == KIND_MEDIAN) ? sorted_ff[MID_INDEX] : '0;
      end
   end

   assign rsp_kind  = kind_ff;
   assign rsp_value = value_ff;

endmodule

[src/ufmf_ctrl.sv]
module ufmf_ctrl
   import ufmf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dp_cmd_type          cmd,
   input  dp_status_type       status
);

   typedef enum logic [2:0] {
      S_READY,
      S_EXEC,
      S_STORE,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MEASURE,
      PH_GAP
   } phase_type;

   state_type           state_ff,    state_in;
   phase_type           phase_ff,    phase_in;
   logic                header_ff,   header_in;
   logic [1:0]          pos_ff,      pos_in;
   logic [COUNT_W-1:0]  readings_ff, readings_in;
   logic [ACTION_W-1:0] action_ff,   action_in;
   logic                kind_ff,     kind_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                do_begin;
   logic                end_gap;

   assign req_ready = (state_ff == S_READY);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      header_in    = header_ff;
      pos_in       = pos_ff;
      readings_in  = readings_ff;
      action_in    = action_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      do_begin     = 1'b0;
      end_gap      = 1'b0;
      cmd          = '0;
      cmd.insert_count = readings_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_READY: begin
            if (req_valid) begin
               action_in      = req_action;
               cmd.latch_byte = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_READY;
            case (action_ff)
               ACT_START: begin
                  if (phase_ff == PH_IDLE) begin
                     readings_in = '0;
                     do_begin    = 1'b1;
                  end
               end
               ACT_BYTE: begin
                  if (phase_ff == PH_MEASURE) begin
                     if (!header_ff) begin
                        if (status.byte_is_header) begin
                           header_in = 1'b1;
                           pos_in    = 2'd1;
                        end
                     end else if (pos_ff == 2'd1) begin
                        cmd.store_hi = 1'b1;
                        pos_in       = 2'd2;
                     end else if (pos_ff == 2'd2) begin
                        cmd.store_lo = 1'b1;
                        pos_in       = 2'd3;
                     end else begin
                        cmd.load_reading = 1'b1;
                        cmd.reading_sel  = status.csum_ok ? RD_QUOT : RD_CSUM_ERR;
                        state_in         = S_STORE;
                     end
                  end
               end
               ACT_TICK: begin
                  if (phase_ff == PH_MEASURE) begin
                     if (status.timeout_hit) begin
                        cmd.load_reading = 1'b1;
                        cmd.reading_sel  = RD_TIMEOUT;
                        state_in         = S_STORE;
                     end else begin
                        cmd.inc_elapsed = 1'b1;
                     end
                  end else if (phase_ff == PH_GAP) begin
                     cmd.inc_elapsed = 1'b1;
                     end_gap         = status.gap_done;
                  end
               end
               default: begin
                  state_in = S_READY;
               end
            endcase
         end
         S_STORE: begin
            state_in = S_READY;
            if (readings_ff < COUNT_W'(READINGS)) begin
               cmd.insert  = 1'b1;
               readings_in = readings_ff + 1'b1;
            end
            header_in       = 1'b0;
            pos_in          = 2'd0;
            cmd.clr_elapsed = 1'b1;
            if (status.gap_zero) begin
               end_gap = 1'b1;
            end else begin
               phase_in = PH_GAP;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = kind_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_READY;
            end
         end
         default: begin
            state_in = S_READY;
         end
      endcase

      if (end_gap) begin
         if (readings_in < COUNT_W'(READINGS)) begin
            do_begin = 1'b1;
         end else begin
            phase_in = PH_IDLE;
            kind_in  = KIND_MEDIAN;
            state_in = S_EMIT;
         end
      end

      if (do_begin) begin
         phase_in        = PH_MEASURE;
         header_in       = 1'b0;
         pos_in          = 2'd0;
         cmd.clr_elapsed = 1'b1;
         kind_in         = KIND_TRIGGER;
         state_in        = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         phase_ff     <= PH_IDLE;
         header_ff    <= 1'b0;
         pos_ff       <= 2'd0;
         readings_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         pos_ff       <= pos_in;
         readings_ff  <= readings_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      kind_ff   <= kind_in;
   end

endmodule

[src/ultrasonic_frame_median_filter_unit.sv]
// Ultrasonic range frame parser with a median-of-13 filter.
// req_item carries one item per valid/ready handshake: action 0 starts a
// series of 13 measurements, action 1 delivers a received serial byte,
// action 2 is a millisecond tick. rsp_item returns kind 0 (send trigger
// byte, value 0) or kind 1 (median distance in cm; 0xFFFE marks a
// checksum error, 0xFFFF a timeout). The csr_ port holds timeout_ms at
// address 0 and gap_ms at address 4.
// Each item passes through accept and execute, plus a store step when it
// closes a reading and an emit step when it produces a result; the
// sequence is set by the controller. A result is loaded into the output
// register in the emit step.
// Sorting is done by a parallel insertion into 13 registers.
// Reset loads timeout_ms 200 and gap_ms 15, returns to idle and drops any
// pending result; no clearing pass is needed.
// While rsp_item is stalled the result is held and further items are
// taken; an item that needs the output register waits in the emit step,
// with req_item.ready low, until the held result is taken.
module ultrasonic_frame_median_filter_unit
   import ufmf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ufmf_req_if.sink              req_item,
   ufmf_rsp_if.source            rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [TICK_W-1:0] timeout_ms;
   logic [GAP_W-1:0]  gap_ms;

   ufmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timeout_ms  (timeout_ms),
      .gap_ms      (gap_ms)
   );

   ufmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_item.valid),
      .req_ready  (req_item.ready),
      .req_action (req_item.action),
      .rsp_valid  (rsp_item.valid),
      .rsp_ready  (rsp_item.ready),
      .cmd        (cmd),
      .status     (status)
   );

   ufmf_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rx_byte    (req_item.rx_byte),
      .timeout_ms (timeout_ms),
      .gap_ms     (gap_ms),
      .rsp_kind   (rsp_item.kind),
      .rsp_value  (rsp_item.value)
   );

endmodule

[src/ufmf_checker.sv]
module ufmf_checker
   import ufmf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_kind,
   input logic [VALUE_W-1:0] rsp_value
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value))
      else $error("stalled result changed");

   a_trigger_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TRIGGER) |-> rsp_value == '0)
      else $error("trigger item with nonzero value");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted on consecutive cycles");

endmodule

bind ultrasonic_frame_median_filter_unit ufmf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_item.valid),
   .req_ready (req_item.ready),
   .rsp_valid (rsp_item.valid),
   .rsp_ready (rsp_item.ready),
   .rsp_kind  (rsp_item.kind),
   .rsp_value (rsp_item.value)
);
